[src/lshm_pkg.sv]
`timescale 1ns / 1ps

package lshm_pkg;

    // Request kinds (tuser)
    localparam logic [1:0] REQ_MEAS   = 2'd0;
    localparam logic [1:0] REQ_REINIT = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    // Begin/reinit outcome codes
    localparam logic [1:0] INIT_BUSY = 2'd0;
    localparam logic [1:0] INIT_OK   = 2'd1;

    // Config register indexes
    localparam logic [2:0] CFG_STUCK_FLOOR   = 3'd0;
    localparam logic [2:0] CFG_STUCK_DELTA   = 3'd1;
    localparam logic [2:0] CFG_STUCK_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_HARD_TIMEOUT  = 3'd3;
    localparam logic [2:0] CFG_FALLBACK      = 3'd4;
    localparam logic [2:0] CFG_EMERGENCY     = 3'd5;
    localparam logic [2:0] CFG_REINIT_GAP    = 3'd6;
    localparam logic [2:0] CFG_SOFT_LIMIT    = 3'd7;

    localparam int LUX_W         = 21;
    localparam int MS_W          = 32;
    localparam int CNT_W         = 8;
    localparam int LUX_FRAC_BITS = 4;
    localparam int BACKOFF_STEPS = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [LUX_W-1:0] FLOOR_RST = LUX_W'(1 << LUX_FRAC_BITS);
    localparam logic [LUX_W-1:0] DELTA_RST = LUX_W'((1 << LUX_FRAC_BITS) >> 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] BACKOFF_LAST = CNT_W'(BACKOFF_STEPS - 1);

    typedef enum logic [1:0] {
        EV_MEAS,
        EV_REINIT,
        EV_START,
        EV_NONE
    } ev_kind_t;

    // first field in the highest bits
    typedef struct packed {
        logic [1:0]       init_outcome;
        logic             link_lost;
        logic             lux_valid;
        logic [LUX_W-1:0] lux_fixed;
        logic [MS_W-1:0]  now_ms;
    } in_payload_t;

    typedef struct packed {
        ev_kind_t         kind;
        logic             init_ok;
        logic             init_fail;
        logic             link_lost;
        logic             lux_valid;
        logic [LUX_W-1:0] lux_fixed;
        logic [MS_W-1:0]  now_ms;
    } ev_t;

    typedef struct packed {
        logic [CNT_W-1:0] fail_count;
        logic             light_available;
        logic             restart_request;
        logic             reinit_request;
        logic             recovered;
        logic             stuck_detected;
        logic             hard_error_new;
        logic             hard_error;
        logic             soft_error;
        logic             sensor_present;
    } res_t;

    typedef struct packed {
        logic [LUX_W-1:0] stuck_floor;
        logic [LUX_W-1:0] stuck_delta;
        logic [MS_W-1:0]  stuck_timeout_ms;
        logic [MS_W-1:0]  hard_timeout_ms;
        logic [MS_W-1:0]  fallback_ms;
        logic [MS_W-1:0]  emergency_ms;
        logic [MS_W-1:0]  reinit_gap_ms;
        logic [CNT_W-1:0] soft_fail_limit;
    } cfg_t;

    localparam int IN_W       = $bits(in_payload_t);
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W      = $bits(res_t);
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Reinit backoff ladder: 15 s, 30 s, 1 min, 5 min, 15 min, then 60 min
    function automatic logic [MS_W-1:0] backoff_ms(input logic [3:0] idx);
        logic [MS_W-1:0] v;
        case (idx)
            4'd0:    v = 32'd15000;
            4'd1:    v = 32'd30000;
            4'd2:    v = 32'd60000;
            4'd3:    v = 32'd300000;
            4'd4:    v = 32'd900000;
            default: v = 32'd3600000;
        endcase
        return v;
    endfunction

endpackage

[src/lshm_front.sv]
`timescale 1ns / 1ps

// Input stage: takes a request, decodes its kind and outcome, hands it to the queue.
module lshm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lshm_pkg::in_payload_t in_data,
    input  logic [1:0]           in_kind,
    output logic                 q_push,
    output lshm_pkg::ev_t        q_item,
    input  logic                 q_full
);

    logic          hold_valid_reg;
    lshm_pkg::ev_t hold_item_reg;
    lshm_pkg::ev_t item_next;

    always_comb
    begin
        item_next.link_lost = in_data.link_lost;
        item_next.lux_valid = in_data.lux_valid;
        item_next.lux_fixed = in_data.lux_fixed;
        item_next.now_ms    = in_data.now_ms;
        item_next.init_ok   = (in_data.init_outcome == lshm_pkg::INIT_OK);
        item_next.init_fail = (in_data.init_outcome != lshm_pkg::INIT_OK) &&
                              (in_data.init_outcome != lshm_pkg::INIT_BUSY);
        case (in_kind)
            lshm_pkg::REQ_MEAS:   item_next.kind = lshm_pkg::EV_MEAS;
            lshm_pkg::REQ_REINIT: item_next.kind = lshm_pkg::EV_REINIT;
            lshm_pkg::REQ_START:  item_next.kind = lshm_pkg::EV_START;
            default:              item_next.kind = lshm_pkg::EV_NONE;
        endcase
    end

    assign q_push   = hold_valid_reg && !q_full;
    assign q_item   = hold_item_reg;
    assign in_ready = !hold_valid_reg || !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_item_reg <= item_next;
        end
    end

endmodule

[src/lshm_queue.sv]
`timescale 1ns / 1ps

// Small FIFO between the decode stage and the state update.
module lshm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lshm_pkg::ev_t push_item,
    output logic          full,
    input  logic          pop,
    output logic          avail,
    output lshm_pkg::ev_t pop_item
);

    localparam int DEPTH = lshm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    lshm_pkg::ev_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign avail    = (fill_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop && avail)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if ((push && !full) && !(pop && avail))
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (!(push && !full) && (pop && avail))
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/lshm_back.sv]
`timescale 1ns / 1ps

// Health state update and result register.
module lshm_back #(
    parameter int TIME_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lshm_pkg::cfg_t cfg,
    input  logic          q_avail,
    input  lshm_pkg::ev_t q_item,
    output logic          q_pop,
    output logic          res_valid,
    input  logic          res_ready,
    output lshm_pkg::res_t res
);

    localparam int LUX_W = lshm_pkg::LUX_W;
    localparam int CNT_W = lshm_pkg::CNT_W;

    // state
    logic                 present_reg, present_next;
    logic                 soft_reg, soft_next;
    logic                 hard_reg, hard_next;
    logic                 trk_reg, trk_next;
    logic [CNT_W-1:0]     inv_cnt_reg, inv_cnt_next;
    logic [CNT_W-1:0]     fails_reg, fails_next;
    logic [LUX_W-1:0]     stk_val_reg, stk_val_next;
    logic [TIME_BITS-1:0] inv_since_reg, inv_since_next;
    logic [TIME_BITS-1:0] hard_since_reg, hard_since_next;
    logic [TIME_BITS-1:0] last_good_reg, last_good_next;
    logic [TIME_BITS-1:0] last_reinit_reg, last_reinit_next;
    logic [TIME_BITS-1:0] stk_since_reg, stk_since_next;

    logic                 out_valid_reg;
    lshm_pkg::res_t       out_reg, out_next;

    // wrapped elapsed time compared to a 32-bit limit
    function automatic logic over(input logic [TIME_BITS-1:0] a,
                                  input logic [TIME_BITS-1:0] b,
                                  input logic [31:0] lim);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return 64'(d) > 64'(lim);
    endfunction

    function automatic logic under(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b,
                                   input logic [31:0] lim);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return 64'(d) < 64'(lim);
    endfunction

    assign q_pop = q_avail && (!out_valid_reg || res_ready);

    always_comb
    begin
        logic [TIME_BITS-1:0] now;
        logic                 valid;
        logic [LUX_W-1:0]     dlux;
        logic [CNT_W-1:0]     step;
        logic [3:0]           idx;

        now   = TIME_BITS'(q_item.now_ms);
        valid = q_item.lux_valid;
        dlux  = '0;
        step  = '0;
        idx   = '0;

        present_next     = present_reg;
        soft_next        = soft_reg;
        hard_next        = hard_reg;
        trk_next         = trk_reg;
        inv_cnt_next     = inv_cnt_reg;
        fails_next       = fails_reg;
        stk_val_next     = stk_val_reg;
        inv_since_next   = inv_since_reg;
        hard_since_next  = hard_since_reg;
        last_good_next   = last_good_reg;
        last_reinit_next = last_reinit_reg;
        stk_since_next   = stk_since_reg;

        out_next = '0;

        case (q_item.kind)
            lshm_pkg::EV_START:
            begin
                last_good_next = now;
                present_next   = q_item.init_ok;
            end
            lshm_pkg::EV_REINIT:
            begin
                if (q_item.init_ok)
                begin
                    present_next   = 1'b1;
                    inv_cnt_next   = '0;
                    inv_since_next = '0;
                    soft_next      = 1'b0;
                    hard_next      = 1'b0;
                    trk_next       = 1'b0;
                    stk_since_next = '0;
                end
                else if (q_item.init_fail)
                begin
                    present_next = 1'b0;
                end
                if ((q_item.init_ok || q_item.init_fail) && fails_reg != lshm_pkg::CNT_MAX)
                begin
                    fails_next = fails_reg + CNT_W'(1);
                end
            end
            lshm_pkg::EV_MEAS:
            begin
                if (q_item.link_lost)
                begin
                    present_next = 1'b0;
                end

                // stuck value watch
                if (valid && q_item.lux_fixed > cfg.stuck_floor)
                begin
                    dlux = (q_item.lux_fixed >= stk_val_reg) ? q_item.lux_fixed - stk_val_reg
                                                             : stk_val_reg - q_item.lux_fixed;
                    if (trk_reg && dlux < cfg.stuck_delta)
                    begin
                        if (stk_since_reg != '0 &&
                            over(now, stk_since_reg, cfg.stuck_timeout_ms))
                        begin
                            out_next.stuck_detected = 1'b1;
                            valid          = 1'b0;
                            present_next   = 1'b0;
                            stk_since_next = now;
                        end
                    end
                    else
                    begin
                        stk_val_next   = q_item.lux_fixed;
                        trk_next       = 1'b1;
                        stk_since_next = now;
                    end
                end
                else
                begin
                    trk_next       = 1'b0;
                    stk_since_next = '0;
                end

                if (!valid)
                begin
                    if (inv_since_reg == '0)
                    begin
                        inv_since_next = now;
                    end
                    step = (inv_cnt_reg != lshm_pkg::CNT_MAX) ? CNT_W'(1) : '0;
                    inv_cnt_next = inv_cnt_reg + step;
                end
                else
                begin
                    out_next.recovered = hard_reg || soft_reg;
                    inv_cnt_next    = '0;
                    inv_since_next  = '0;
                    soft_next       = 1'b0;
                    hard_next       = 1'b0;
                    hard_since_next = '0;
                    last_good_next  = now;
                    fails_next      = '0;
                end

                if (present_next && inv_cnt_next >= cfg.soft_fail_limit)
                begin
                    soft_next = 1'b1;
                end

                if (present_next && inv_since_next != '0 && !hard_next &&
                    over(now, inv_since_next, cfg.hard_timeout_ms))
                begin
                    hard_next               = 1'b1;
                    present_next            = 1'b0;
                    out_next.hard_error_new = 1'b1;
                    if (hard_since_next == '0)
                    begin
                        hard_since_next = now;
                    end
                end

                // paced reinit with backoff on consecutive failures
                idx = (fails_next > lshm_pkg::BACKOFF_LAST) ? 4'(lshm_pkg::BACKOFF_LAST)
                                                            : 4'(fails_next);
                if (!present_next && over(now, last_reinit_reg, cfg.reinit_gap_ms) &&
                    !under(now, last_reinit_reg, lshm_pkg::backoff_ms(idx)))
                begin
                    last_reinit_next        = now;
                    out_next.reinit_request = 1'b1;
                end

                out_next.restart_request = hard_next && hard_since_next != '0 &&
                                           over(now, hard_since_next, cfg.emergency_ms);
            end
            default:
            begin
            end
        endcase

        out_next.sensor_present  = present_next;
        out_next.soft_error      = soft_next;
        out_next.hard_error      = hard_next;
        out_next.fail_count      = inv_cnt_next;
        out_next.light_available = present_next && !hard_next &&
                                   under(now, last_good_next, cfg.fallback_ms);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg     <= 1'b0;
            soft_reg        <= 1'b0;
            hard_reg        <= 1'b0;
            trk_reg         <= 1'b0;
            inv_cnt_reg     <= '0;
            fails_reg       <= '0;
            stk_val_reg     <= '0;
            inv_since_reg   <= '0;
            hard_since_reg  <= '0;
            last_good_reg   <= '0;
            last_reinit_reg <= '0;
            stk_since_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                present_reg     <= present_next;
                soft_reg        <= soft_next;
                hard_reg        <= hard_next;
                trk_reg         <= trk_next;
                inv_cnt_reg     <= inv_cnt_next;
                fails_reg       <= fails_next;
                stk_val_reg     <= stk_val_next;
                inv_since_reg   <= inv_since_next;
                hard_since_reg  <= hard_since_next;
                last_good_reg   <= last_good_next;
                last_reinit_reg <= last_reinit_next;
                stk_since_reg   <= stk_since_next;
                out_valid_reg   <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_new_hard_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.hard_error_new |-> out_reg.hard_error && !out_reg.sensor_present)
        else $error("new hard error without hard flag");

    a_restart_needs_hard: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.restart_request |-> out_reg.hard_error)
        else $error("restart request without hard error");

    a_recover_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.recovered |-> out_reg.fail_count == '0 && !out_reg.hard_error)
        else $error("recovery left invalid count or hard flag");

    a_avail_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.light_available |->
            out_reg.sensor_present && !out_reg.hard_error)
        else $error("available while absent or in hard error");

    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg && out_reg.fail_count == inv_cnt_reg &&
                  out_reg.sensor_present == present_reg)
        else $error("result register out of step with state");

endmodule

[src/light_sensor_health_monitor_unit.sv]
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: event fields, tuser: req_type
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: status flags and fail_count
// cfg       | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// One request per cycle sustained while m_axis accepts results. A request passes
// the decode register, the two-entry queue and the state update into the result
// register. The state update is a read-modify-write done in the same cycle as the pop.
// rst_n clears the health state, queue and result valid and loads register defaults.
// A stalled m_axis fills the result register, then the queue, then the decode
// register before s_axis_tready drops; cfg_ready is always high.
module light_sensor_health_monitor_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] now_ms, [52:32] lux_fixed, [53] lux_valid, [54] link_lost,
    // [56:55] init_outcome, [63:57] zero
    input  logic [lshm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] sensor_present, [1] soft_error, [2] hard_error, [3] hard_error_new,
    // [4] stuck_detected, [5] recovered, [6] reinit_request, [7] restart_request,
    // [8] light_available, [16:9] fail_count, [23:17] zero
    output logic [lshm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [2:0]                         cfg_index,
    input  logic [31:0]                        cfg_data
);

    lshm_pkg::cfg_t        cfg_reg;
    lshm_pkg::in_payload_t in_data;
    lshm_pkg::ev_t         push_item;
    lshm_pkg::ev_t         pop_item;
    lshm_pkg::res_t        res;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_avail;

    assign in_data   = s_axis_tdata[lshm_pkg::IN_W-1:0];
    assign cfg_ready = 1'b1;

    // Register file; values are truncated to each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stuck_floor      <= lshm_pkg::FLOOR_RST;
            cfg_reg.stuck_delta      <= lshm_pkg::DELTA_RST;
            cfg_reg.stuck_timeout_ms <= 32'd1800000;
            cfg_reg.hard_timeout_ms  <= 32'd60000;
            cfg_reg.fallback_ms      <= 32'd300000;
            cfg_reg.emergency_ms     <= 32'd7200000;
            cfg_reg.reinit_gap_ms    <= 32'd15000;
            cfg_reg.soft_fail_limit  <= 8'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lshm_pkg::CFG_STUCK_FLOOR:   cfg_reg.stuck_floor      <= cfg_data[20:0];
                lshm_pkg::CFG_STUCK_DELTA:   cfg_reg.stuck_delta      <= cfg_data[20:0];
                lshm_pkg::CFG_STUCK_TIMEOUT: cfg_reg.stuck_timeout_ms <= cfg_data;
                lshm_pkg::CFG_HARD_TIMEOUT:  cfg_reg.hard_timeout_ms  <= cfg_data;
                lshm_pkg::CFG_FALLBACK:      cfg_reg.fallback_ms      <= cfg_data;
                lshm_pkg::CFG_EMERGENCY:     cfg_reg.emergency_ms     <= cfg_data;
                lshm_pkg::CFG_REINIT_GAP:    cfg_reg.reinit_gap_ms    <= cfg_data;
                lshm_pkg::CFG_SOFT_LIMIT:    cfg_reg.soft_fail_limit  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    lshm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (in_data),
        .in_kind  (s_axis_tuser),
        .q_push   (q_push),
        .q_item   (push_item),
        .q_full   (q_full)
    );

    lshm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_item  (pop_item)
    );

    lshm_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_avail   (q_avail),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {(lshm_pkg::OUT_TDATA_W - lshm_pkg::OUT_W)'(0), res};

endmodule
